### design/seven_bit_code_unpacker_top_assert.svh
// Assertion macros for the seven-bit code unpacker.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef SEVEN_BIT_CODE_UNPACKER_TOP_ASSERT_SVH
`define SEVEN_BIT_CODE_UNPACKER_TOP_ASSERT_SVH

// Condition must never hold outside reset.
`define SBCU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SBCU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/sbcu_pkg.sv
// Shared types and constants for the seven-bit code unpacker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sbcu_pkg;

    localparam int CODE_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CODE_W-1:0] END_CODE = 7'd127;
    localparam logic [2:0]        LAST_POS = 3'd6;

    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_TABLE = 1'b1;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_kind_t;

    // One unit of work for the back end: a table lookup or a table write.
    typedef struct packed {
        op_kind_t            kind;
        logic [CODE_W-1:0]   addr;
        logic [BYTE_W-1:0]   symbol;
        logic                zero;
        logic                last;
    } op_t;

    typedef struct packed {
        logic                pend_valid;
        logic [2:0]          pos;
    } front_status_t;

endpackage

### design/seven_bit_code_unpacker_top.sv
// Seven-bit code unpacker: takes packed data beats and table-write beats on
// one valid/ready channel and returns decoded symbol bytes on another. Every
// seven data beats form a group carrying eight 7-bit codes, MSB first; each
// code reads the symbol table and gives one byte, or zero when the code is
// at or above table_length (cfg_write_en/cfg_write_data; the user must write
// it only while the block is idle; the block does not enforce this). Code
// 127 marks the end of a group's data: it gives nothing, and the rest of
// that group gives nothing either, while alignment is still kept.
// last_of_run flags the final result of a beat. Rate: one beat per cycle
// while the op queue has room; as it accepts one op per cycle, a seventh
// beat that yields two symbols holds its second code, and new beats wait
// until it is queued. A beat's first result passes the queue, the table
// read register and the output register. Table slots must be written
// before they are read; the table gets no clearing pass after reset.
// Depends on sbcu_pkg, sbcu_front, sbcu_queue, sbcu_back and the assert header.
`timescale 1ns / 1ps

`include "seven_bit_code_unpacker_top_assert.svh"

module seven_bit_code_unpacker_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [sbcu_pkg::CODE_W-1:0] cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [sbcu_pkg::BYTE_W-1:0] packed_byte,
    input  logic [sbcu_pkg::CODE_W-1:0] entry_index,
    input  logic [sbcu_pkg::BYTE_W-1:0] entry_symbol,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sbcu_pkg::BYTE_W-1:0] symbol_out,
    output logic                        last_of_run
);

    // Front to queue
    logic                    q_push;
    logic                    q_full;
    sbcu_pkg::op_t           q_push_op;
    sbcu_pkg::front_status_t front_status;

    // Queue to back
    logic                    q_pop;
    logic                    q_valid;
    sbcu_pkg::op_t           q_head_op;

    // Front end: classify each beat, split group position six into two ops.
    sbcu_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .packed_byte    (packed_byte),
        .entry_index    (entry_index),
        .entry_symbol   (entry_symbol),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_op           (q_push_op),
        .status         (front_status)
    );

    // Decouple: hold ops so front and back stall independently.
    sbcu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (q_head_op)
    );

    // Back end: apply writes, look up codes, present results.
    sbcu_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_op        (q_head_op),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .symbol_out  (symbol_out),
        .last_of_run (last_of_run)
    );

    // Never push into a full queue, never pop an empty one.
    `SBCU_ASSERT_NEVER(a_queue_overflow, q_push && q_full, "op queue overflow")
    `SBCU_ASSERT_NEVER(a_queue_underflow, q_pop && !q_valid, "op queue underflow")
    // Hold off new beats while a second code is still waiting to enter the queue.
    `SBCU_ASSERT_IMPL(a_pend_blocks_input, front_status.pend_valid, !in_ready, "beat taken during pending code")
    // A second code is only held after the last byte of a group.
    `SBCU_ASSERT_IMPL(a_pend_at_group_start, front_status.pend_valid, front_status.pos == 3'd0, "pending code outside group end")

endmodule

### design/sbcu_front.sv
// Front end: accepts beats, extracts 7-bit codes, tracks group state.
// Depends on sbcu_pkg; feeds sbcu_queue with lookup and write ops.
`timescale 1ns / 1ps

module sbcu_front #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [sbcu_pkg::CODE_W-1:0]       cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [sbcu_pkg::BYTE_W-1:0]       packed_byte,
    input  logic [sbcu_pkg::CODE_W-1:0]       entry_index,
    input  logic [sbcu_pkg::BYTE_W-1:0]       entry_symbol,
    input  logic                              q_full,
    output logic                              q_push,
    output sbcu_pkg::op_t                     q_op,
    output sbcu_pkg::front_status_t           status
);

    localparam logic [sbcu_pkg::CODE_W:0] DEPTH_LIM = (sbcu_pkg::CODE_W + 1)'(TABLE_DEPTH);

    logic [sbcu_pkg::CODE_W-1:0] table_length_reg;
    logic [sbcu_pkg::BYTE_W-1:0] prev_byte_reg, prev_byte_next;
    logic [2:0]                  pos_reg, pos_next;
    logic                        stopped_reg, stopped_next;
    logic                        pend_valid_reg, pend_valid_next;
    sbcu_pkg::op_t               pend_op_reg, pend_op_next;

    logic [2:0]                  pos_eff;
    logic [2*sbcu_pkg::BYTE_W-1:0] window;
    logic [sbcu_pkg::CODE_W-1:0] code_a, code_b;
    logic                        emit_a, emit_b, stop_after_a, at_last;
    logic                        zero_a, zero_b;
    logic                        accept, accept_data;
    sbcu_pkg::op_t               op_a, op_b, op_wr;

    always_comb
    begin
        pos_eff      = (pos_reg > sbcu_pkg::LAST_POS) ? 3'd0 : pos_reg;
        window       = {prev_byte_reg, packed_byte};
        code_a       = sbcu_pkg::CODE_W'(window >> ({1'b0, pos_eff} + 4'd1));
        code_b       = packed_byte[sbcu_pkg::CODE_W-1:0];
        at_last      = (pos_eff == sbcu_pkg::LAST_POS);
        stop_after_a = stopped_reg || (code_a == sbcu_pkg::END_CODE);
        emit_a       = !stop_after_a;
        emit_b       = at_last && !stop_after_a && (code_b != sbcu_pkg::END_CODE);
        zero_a       = (code_a >= table_length_reg) || ({1'b0, code_a} >= DEPTH_LIM);
        zero_b       = (code_b >= table_length_reg) || ({1'b0, code_b} >= DEPTH_LIM);

        op_a.kind    = sbcu_pkg::OP_LOOKUP;
        op_a.addr    = code_a;
        op_a.symbol  = '0;
        op_a.zero    = zero_a;
        op_a.last    = !emit_b;

        op_b.kind    = sbcu_pkg::OP_LOOKUP;
        op_b.addr    = code_b;
        op_b.symbol  = '0;
        op_b.zero    = zero_b;
        op_b.last    = 1'b1;

        op_wr.kind   = sbcu_pkg::OP_WRITE;
        op_wr.addr   = entry_index;
        op_wr.symbol = entry_symbol;
        op_wr.zero   = 1'b0;
        op_wr.last   = 1'b0;
    end

    assign in_ready    = !pend_valid_reg && !q_full;
    assign accept      = in_valid && in_ready;
    assign accept_data = accept && (req_type == sbcu_pkg::REQ_DATA);

    // Push path: the held second code first, otherwise the beat just taken.
    always_comb
    begin
        q_push = 1'b0;
        q_op   = op_a;
        if (pend_valid_reg)
        begin
            q_push = !q_full;
            q_op   = pend_op_reg;
        end
        else if (accept)
        begin
            if (req_type == sbcu_pkg::REQ_TABLE)
            begin
                // drop writes to slots beyond the table
                q_push = ({1'b0, entry_index} < DEPTH_LIM);
                q_op   = op_wr;
            end
            else
            begin
                q_push = emit_a;
                q_op   = op_a;
            end
        end
    end

    always_comb
    begin
        prev_byte_next  = prev_byte_reg;
        pos_next        = pos_reg;
        stopped_next    = stopped_reg;
        pend_valid_next = pend_valid_reg;
        pend_op_next    = pend_op_reg;
        if (pend_valid_reg && !q_full)
        begin
            pend_valid_next = 1'b0;
        end
        if (accept_data)
        begin
            prev_byte_next = packed_byte;
            pos_next       = at_last ? 3'd0 : pos_eff + 3'd1;
            stopped_next   = at_last ? 1'b0 : stop_after_a;
            if (emit_a && emit_b)
            begin
                pend_valid_next = 1'b1;
                pend_op_next    = op_b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
            prev_byte_reg    <= '0;
            pos_reg          <= '0;
            stopped_reg      <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                table_length_reg <= cfg_write_data;
            end
            prev_byte_reg  <= prev_byte_next;
            pos_reg        <= pos_next;
            stopped_reg    <= stopped_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg <= pend_op_next;
    end

    assign status.pend_valid = pend_valid_reg;
    assign status.pos        = pos_reg;

endmodule

### design/sbcu_queue.sv
// Small op queue between front and back end.
// Depends on sbcu_pkg for the op type and depth.
`timescale 1ns / 1ps

module sbcu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sbcu_pkg::op_t push_op,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output sbcu_pkg::op_t head_op
);

    sbcu_pkg::op_t                 slot_reg [sbcu_pkg::QUEUE_DEPTH];
    logic [sbcu_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [sbcu_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [sbcu_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full    = (count_reg == sbcu_pkg::QCNT_W'(sbcu_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### design/sbcu_back.sv
// Back end: symbol table memory, registered lookup and output register.
// Depends on sbcu_pkg; drains ops from sbcu_queue.
`timescale 1ns / 1ps

module sbcu_back #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  sbcu_pkg::op_t               q_op,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sbcu_pkg::BYTE_W-1:0] symbol_out,
    output logic                        last_of_run
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [sbcu_pkg::BYTE_W-1:0] mem [TABLE_DEPTH];
    logic [sbcu_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_zero_reg, s1_last_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [sbcu_pkg::BYTE_W-1:0] out_sym_reg;
    logic                        out_last_reg;

    logic s1_adv, s1_free, pop_lookup, pop_write;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign s1_free    = !s1_valid_reg || s1_adv;
    assign pop_lookup = q_valid && (q_op.kind == sbcu_pkg::OP_LOOKUP) && s1_free;
    assign pop_write  = q_valid && (q_op.kind == sbcu_pkg::OP_WRITE);
    assign q_pop      = pop_lookup || pop_write;

    always_comb
    begin
        s1_valid_next  = pop_lookup || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && !out_ready);
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (pop_write)
        begin
            mem[q_op.addr[AW-1:0]] <= q_op.symbol;
        end
        if (pop_lookup)
        begin
            rd_data_reg <= mem[q_op.addr[AW-1:0]];
            s1_zero_reg <= q_op.zero;
            s1_last_reg <= q_op.last;
        end
        if (s1_adv)
        begin
            out_sym_reg  <= s1_zero_reg ? '0 : rd_data_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign symbol_out  = out_sym_reg;
    assign last_of_run = out_last_reg;

endmodule

### tb/seven_bit_code_unpacker_top_tb.sv
// Self-checking testbench for seven_bit_code_unpacker_top: random and directed beats
// checked against an in-bench decoder. Depends on sbcu_pkg and the block's RTL only.
`timescale 1ns / 1ps

module seven_bit_code_unpacker_top_tb;

    localparam int                  BYTE_W    = sbcu_pkg::BYTE_W;
    localparam int                  CODE_W    = sbcu_pkg::CODE_W;
    localparam logic                REQ_DATA  = sbcu_pkg::REQ_DATA;
    localparam logic                REQ_TABLE = sbcu_pkg::REQ_TABLE;
    localparam logic [CODE_W-1:0]   END_CODE  = sbcu_pkg::END_CODE;
    localparam logic [2:0]          LAST_POS  = sbcu_pkg::LAST_POS;

    localparam int CLK_HALF      = 4;
    localparam int TBL_DEPTH     = 128;
    localparam int SETTLE_CYCLES = 10;      // margin for the block's pipeline to empty
    localparam int DRAIN_LIMIT   = 100000;
    localparam int SEG_BEATS     = 275;
    localparam int SHOW_LIMIT    = 10;

    // One input beat as the bench holds it before driving.
    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic [CODE_W-1:0] idx;
        logic [BYTE_W-1:0] sym;
    } beat_t;

    // One decoded symbol as the block should return it.
    typedef struct {
        logic [BYTE_W-1:0] sym;
        logic              last;
    } symbol_result_t;

    // Clock, reset and DUT ports; every input starts at a known value.
    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic [CODE_W-1:0] cfg_write_data = '0;
    logic              in_valid       = 1'b0;
    logic              in_ready;
    logic              req_type       = REQ_DATA;
    logic [BYTE_W-1:0] packed_byte    = '0;
    logic [CODE_W-1:0] entry_index    = '0;
    logic [BYTE_W-1:0] entry_symbol   = '0;
    logic              out_valid;
    logic              out_ready      = 1'b0;
    logic [BYTE_W-1:0] symbol_out;
    logic              last_of_run;

    // Beats waiting to be driven, and symbols waiting to come back.
    beat_t          beat_q[$];
    symbol_result_t symbol_q[$];

    // Decoder state kept by the bench.
    logic [BYTE_W-1:0] dec_prev;
    logic [2:0]        dec_pos;
    logic              dec_stopped;
    logic [BYTE_W-1:0] dec_table [TBL_DEPTH];
    logic [CODE_W-1:0] dec_tlen;

    // Driver and monitor controls.
    beat_t          cur_beat;
    logic           drain_hold;
    logic           send_hold_off;
    int             send_idle_pct;
    int             recv_idle_pct;
    int             send_free_run;
    int             recv_free_run;
    int             write_pct;
    int             stream_pos;
    symbol_result_t head_want;

    // Run statistics.
    int fail_count;
    int n_pushed;
    int n_data;
    int n_writes;
    int n_results;
    int n_markers;
    int n_cfg;

    seven_bit_code_unpacker_top #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .packed_byte    (packed_byte),
        .entry_index    (entry_index),
        .entry_symbol   (entry_symbol),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .symbol_out     (symbol_out),
        .last_of_run    (last_of_run)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------

    // Resolve one code: drop it in a stopped group, stop the group on the end
    // marker, otherwise look it up (zero at or beyond the table length).
    function automatic logic resolve_code(input logic [CODE_W-1:0] code,
                                          output logic [BYTE_W-1:0] sym);
        sym = '0;
        if (dec_stopped)
            return 1'b0;
        if (code == END_CODE)
        begin
            dec_stopped = 1'b1;
            n_markers++;
            return 1'b0;
        end
        sym = (code < dec_tlen) ? dec_table[code] : '0;
        return 1'b1;
    endfunction

    // Advance the decoder by one accepted beat and queue the symbols it yields.
    function automatic void decode_beat(input beat_t b);
        logic [BYTE_W-1:0] syms [2];
        logic [BYTE_W-1:0] sym;
        logic [CODE_W-1:0] code;
        symbol_result_t    r;
        int                n;
        int                p;
        int                k;
        if (b.kind == REQ_TABLE)
        begin
            dec_table[b.idx] = b.sym;
            n_writes++;
            return;
        end
        n_data++;
        n = 0;
        p = int'(dec_pos);
        // Low bits of the previous byte join the high bits of this one.
        code = CODE_W'(((int'(dec_prev) << (7 - p)) & 127) | (int'(b.data) >> (p + 1)));
        if (resolve_code(code, sym))
        begin
            syms[n] = sym;
            n++;
        end
        // The seventh byte of a group also closes the eighth code.
        if (p == int'(LAST_POS))
        begin
            code = b.data[CODE_W-1:0];
            if (resolve_code(code, sym))
            begin
                syms[n] = sym;
                n++;
            end
        end
        for (k = 0; k < n; k++)
        begin
            r.sym  = syms[k];
            r.last = (k == n - 1);
            symbol_q.push_back(r);
        end
        dec_prev = b.data;
        p++;
        if (p > int'(LAST_POS))
        begin
            p = 0;
            dec_stopped = 1'b0;
        end
        dec_pos = 3'(p);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present beats from beat_q, idle at random, hold for drains
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // Beat taken at this edge: advance the decoder.
            if (in_valid && in_ready)
            begin
                decode_beat(cur_beat);
                // Now and then hold the next beat until every symbol is back.
                if ($urandom_range(0, 199) == 0)
                    drain_hold = 1'b1;
            end
            // Slot is free after this edge: decide whether to present a beat.
            if (!in_valid || in_ready)
            begin
                if (drain_hold && symbol_q.size() == 0)
                    drain_hold = 1'b0;
                if (send_free_run > 0)
                    send_free_run--;
                else if ($urandom_range(0, 99) == 0)
                    send_free_run = $urandom_range(10, 60);
                send_hold_off = (send_free_run == 0) &&
                                ($urandom_range(0, 99) < send_idle_pct);
                if (beat_q.size() > 0 && !drain_hold && !send_hold_off)
                begin
                    cur_beat = beat_q.pop_front();
                    in_valid     <= 1'b1;
                    req_type     <= cur_beat.kind;
                    packed_byte  <= cur_beat.data;
                    entry_index  <= cur_beat.idx;
                    entry_symbol <= cur_beat.sym;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall at random, compare each taken symbol with the oldest one due
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (symbol_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("[%0t] unexpected result: symbol_out %h last_of_run %b",
                                 $realtime, symbol_out, last_of_run);
                end
                else
                begin
                    head_want = symbol_q.pop_front();
                    n_results++;
                    if (symbol_out !== head_want.sym)
                    begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT)
                            $display("[%0t] symbol_out mismatch: expected %h, got %h",
                                     $realtime, head_want.sym, symbol_out);
                    end
                    if (last_of_run !== head_want.last)
                    begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT)
                            $display("[%0t] last_of_run mismatch: expected %b, got %b",
                                     $realtime, head_want.last, last_of_run);
                    end
                end
            end
            if (recv_free_run > 0)
                recv_free_run--;
            else if ($urandom_range(0, 99) == 0)
                recv_free_run = $urandom_range(10, 60);
            out_ready <= (recv_free_run > 0) || ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one data beat; fill the unused table fields with noise.
    task automatic push_data(input logic [BYTE_W-1:0] value);
        beat_t b;
        b.kind = REQ_DATA;
        b.data = value;
        b.idx  = CODE_W'($urandom_range(0, 127));
        b.sym  = BYTE_W'($urandom_range(0, 255));
        beat_q.push_back(b);
        n_pushed++;
        stream_pos = (stream_pos + 1) % 7;
    endtask

    // Queue one table write; fill the unused data field with noise.
    task automatic push_write(input logic [CODE_W-1:0] idx, input logic [BYTE_W-1:0] sym);
        beat_t b;
        b.kind = REQ_TABLE;
        b.data = BYTE_W'($urandom_range(0, 255));
        b.idx  = idx;
        b.sym  = sym;
        beat_q.push_back(b);
        n_pushed++;
    endtask

    // Pack eight codes MSB first into seven data beats, with table writes
    // sprinkled in between at write_pct percent.
    task automatic push_group(input logic [0:7][CODE_W-1:0] codes);
        logic [55:0] bits;
        int          k;
        bits = codes;
        for (k = 0; k < 7; k++)
        begin
            if ($urandom_range(0, 99) < write_pct)
                push_write(CODE_W'($urandom_range(0, 127)), BYTE_W'($urandom_range(0, 255)));
            push_data(bits[55 - 8 * k -: 8]);
        end
    endtask

    // Code choice biased toward the table-length boundary.
    function automatic logic [CODE_W-1:0] pick_code();
        int c;
        int lim;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                c = $urandom_range(0, 126);
            4, 5, 6:
            begin
                c = int'(dec_tlen) + int'($urandom_range(0, 4)) - 2;
                if (c < 0)
                    c = 0;
                if (c > 126)
                    c = 126;
            end
            default:
            begin
                lim = (dec_tlen == 0) ? 0 : int'(dec_tlen) - 1;
                if (lim > 126)
                    lim = 126;
                c = $urandom_range(0, lim);
            end
        endcase
        return CODE_W'(c);
    endfunction

    // Queue about count random beats: mostly aligned groups, some loose bytes.
    task automatic push_random(input int count);
        logic [0:7][CODE_W-1:0] codes;
        int                     start;
        int                     k;
        start = n_pushed;
        while (n_pushed - start < count)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                // Loose bytes shift the group boundary away from the generator's.
                repeat ($urandom_range(1, 6))
                    push_data(BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                while (stream_pos != 0)
                    push_data(BYTE_W'($urandom_range(0, 255)));
                for (k = 0; k < 8; k++)
                    codes[k] = pick_code();
                if ($urandom_range(0, 5) == 0)
                    codes[$urandom_range(0, 7)] = END_CODE;
                push_group(codes);
            end
        end
    endtask

    // Wait until the block is idle, then write table_length.
    task automatic set_table_length(input logic [CODE_W-1:0] value);
        while (beat_q.size() != 0 || in_valid || symbol_q.size() != 0)
            @(negedge clk);
        // Table writes give no result; let the pipeline empty behind them.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        dec_tlen = value;
        n_cfg++;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        int i;
        int seg;
        int waited;
        logic [CODE_W-1:0] tl;

        dec_prev      = '0;
        dec_pos       = '0;
        dec_stopped   = 1'b0;
        dec_tlen      = '0;
        drain_hold    = 1'b0;
        send_hold_off = 1'b0;
        send_free_run = 0;
        recv_free_run = 0;
        write_pct     = 0;
        stream_pos    = 0;
        fail_count    = 0;
        n_pushed      = 0;
        n_data        = 0;
        n_writes      = 0;
        n_results     = 0;
        n_markers     = 0;
        n_cfg         = 0;
        send_idle_pct = 33;
        recv_idle_pct = 85;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load every slot so that no lookup ever reads an unwritten entry.
        for (i = 0; i < TBL_DEPTH; i++)
            push_write(CODE_W'(i), BYTE_W'($urandom_range(0, 255)));

        // Directed: full table, extremes of codes and both late end-marker spots.
        set_table_length(7'd127);
        push_group({7'd0, 7'd126, 7'd85, 7'd42, 7'd1, 7'd125, 7'd63, 7'd64});
        push_write(7'd3, 8'h00);
        push_write(7'd4, 8'hFF);
        // End marker as code 6: the seventh byte gives nothing at all.
        push_group({7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, END_CODE, 7'd9});
        // End marker as code 7: the seventh byte gives a single symbol.
        push_group({7'd4, 7'd3, 7'd2, 7'd1, 7'd0, 7'd126, 7'd7, END_CODE});
        // Short table: codes on both sides of the boundary, marker mid-group.
        set_table_length(7'd10);
        push_group({7'd9, 7'd10, 7'd11, 7'd126, 7'd0, END_CODE, 7'd1, 7'd2});

        // Random: two segments per idling mode, table_length varied each time.
        write_pct = 8;
        for (seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0: tl = 7'd127;
                1: tl = 7'd0;
                3: tl = 7'd1;
                5: tl = 7'd126;
                default: tl = CODE_W'($urandom_range(2, 125));
            endcase
            set_table_length(tl);
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            push_random(SEG_BEATS);
        end

        // Drain: all beats taken, then all symbols back, then a few quiet cycles.
        while (beat_q.size() != 0 || in_valid)
            @(negedge clk);
        waited = 0;
        while (symbol_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (symbol_q.size() != 0)
        begin
            fail_count++;
            $display("%0d expected symbols never came out", symbol_q.size());
        end

        $display("Covered %0d data beats and %0d table writes over %0d table_length settings.",
                 n_data, n_writes, n_cfg);
        $display("Compared %0d symbols, %0d end markers decoded, %0d failures.",
                 n_results, n_markers, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
